FILE: rtl/block_indexed_search_top_macros.svh
// Assertion macros used by the block's sequencer.
`ifndef BLOCK_INDEXED_SEARCH_TOP_MACROS_SVH
`define BLOCK_INDEXED_SEARCH_TOP_MACROS_SVH

`ifndef SYNTH
`define BIS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define BIS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BIS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BIS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/bis_pkg.sv
package bis_pkg;

   localparam int DEF_MAX_BLOCKS    = 4;
   localparam int DEF_MAX_BLOCK_LEN = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int BIU_RESET  = 3;
   localparam int BLEN_RESET = 6;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic REG_BLOCKS_IN_USE = 1'b0;
   localparam logic REG_BLOCK_LENGTH  = 1'b1;

   typedef logic signed [15:0] elem_type;
   typedef logic [1:0]         blk_fld_type;
   typedef logic [2:0]         off_fld_type;
   typedef logic [4:0]         pos_type;
   typedef logic [2:0]         biu_type;
   typedef logic [3:0]         len_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      biu_type blocks_in_use;
      len_type block_length;
   } cfg_type;

   typedef struct packed {
      logic        en;
      blk_fld_type blk;
      off_fld_type off;
      elem_type    value;
   } load_type;

   typedef struct packed {
      logic    en;
      biu_type blk;
      len_type off;
   } rd_type;

   typedef struct packed {
      logic ge_key;
      logic lt_bound;
      logic eq_key;
   } cmp_type;

   function automatic int clamp_range(int v, int lo, int hi);
      int r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

FILE: rtl/bis_if.sv
interface bis_req_if;
   import bis_pkg::*;

   logic        valid;
   logic        ready;
   logic        command;
   blk_fld_type block_number;
   off_fld_type offset;
   elem_type    element_value;
   elem_type    search_key;

   modport source (output valid, command, block_number, offset, element_value, search_key,
                   input ready);
   modport sink   (input valid, command, block_number, offset, element_value, search_key,
                   output ready);
endinterface

interface bis_rsp_if;
   import bis_pkg::*;

   logic        valid;
   logic        ready;
   logic        found;
   blk_fld_type found_block;
   off_fld_type found_offset;
   pos_type     found_position;

   modport source (output valid, found, found_block, found_offset, found_position,
                   input ready);
   modport sink   (input valid, found, found_block, found_offset, found_position,
                   output ready);
endinterface

FILE: rtl/bis_csr.sv
module bis_csr #(
   parameter int MAX_BLOCKS    = bis_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_BLOCK_LEN = bis_pkg::DEF_MAX_BLOCK_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bis_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bis_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bis_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output bis_pkg::cfg_type                cfg
);
   import bis_pkg::*;

   localparam biu_type BIU_RST  = biu_type'(clamp_range(BIU_RESET, 1, MAX_BLOCKS));
   localparam len_type BLEN_RST = len_type'(clamp_range(BLEN_RESET, 1, MAX_BLOCK_LEN));

   biu_type biu_ff, biu_in;
   len_type blen_ff, blen_in;
   logic    wr_en;
   logic    reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_sel = paddr[2];

   always_comb begin
      biu_in  = biu_ff;
      blen_in = blen_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_BLOCKS_IN_USE: begin
               biu_in = biu_type'(clamp_range(int'(pwdata[2:0]), 1, MAX_BLOCKS));
            end
            REG_BLOCK_LENGTH: begin
               blen_in = len_type'(clamp_range(int'(pwdata[3:0]), 1, MAX_BLOCK_LEN));
            end
            default: begin
               biu_in = biu_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff  <= BIU_RST;
         blen_ff <= BLEN_RST;
      end else begin
         biu_ff  <= biu_in;
         blen_ff <= blen_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BLOCKS_IN_USE: prdata = CSR_DATA_W'(biu_ff);
         REG_BLOCK_LENGTH:  prdata = CSR_DATA_W'(blen_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.blocks_in_use = biu_ff;
   assign cfg.block_length  = blen_ff;
endmodule

FILE: rtl/bis_store.sv
module bis_store #(
   parameter int MAX_BLOCKS    = bis_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_BLOCK_LEN = bis_pkg::DEF_MAX_BLOCK_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  bis_pkg::cfg_type   cfg,
   input  bis_pkg::load_type  ld,
   input  bis_pkg::rd_type    rd,
   input  bis_pkg::biu_type   sel_blk,
   output bis_pkg::elem_type  rdata,
   output bis_pkg::elem_type  max_sel
);
   import bis_pkg::*;

   localparam int DEPTH = MAX_BLOCKS * MAX_BLOCK_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   elem_type mem [DEPTH];
   elem_type max_ff [MAX_BLOCKS];
   elem_type rdata_ff;

   logic [31:0]   ld_blk_wide;
   logic [31:0]   wr_addr_wide;
   logic [31:0]   rd_addr_wide;
   logic [31:0]   sel_wide;
   logic [BW-1:0] ld_blk_idx;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          ld_ok;

   assign ld_blk_wide  = 32'(ld.blk);
   assign ld_blk_idx   = ld_blk_wide[BW-1:0];
   assign wr_addr_wide = 32'(ld.blk) * 32'(MAX_BLOCK_LEN) + 32'(ld.off);
   assign wr_addr      = wr_addr_wide[AW-1:0];
   assign rd_addr_wide = 32'(rd.blk) * 32'(MAX_BLOCK_LEN) + 32'(rd.off);
   assign rd_addr      = rd_addr_wide[AW-1:0];
   assign sel_wide     = 32'(sel_blk);

   assign ld_ok = ld.en && (ld_blk_wide < 32'(MAX_BLOCKS))
                  && (32'(ld.off) < 32'(cfg.block_length))
                  && (32'(ld.off) < 32'(MAX_BLOCK_LEN));

   always_ff @(posedge clock) begin
      if (ld_ok) begin
         mem[wr_addr] <= ld.value;
      end
      if (rd.en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            max_ff[i] <= '0;
         end
      end else if (ld_ok) begin
         if (ld.value > max_ff[ld_blk_idx]) begin
            max_ff[ld_blk_idx] <= ld.value;
         end
      end
   end

   assign rdata   = rdata_ff;
   assign max_sel = (sel_wide < 32'(MAX_BLOCKS)) ? max_ff[sel_wide[BW-1:0]] : '0;
endmodule

FILE: rtl/bis_cmp.sv
module bis_cmp (
   input  bis_pkg::elem_type cand,
   input  bis_pkg::elem_type key,
   input  bis_pkg::elem_type bound,
   output bis_pkg::cmp_type  res
);
   import bis_pkg::*;

   assign res.ge_key   = (cand >= key);
   assign res.lt_bound = (cand < bound);
   assign res.eq_key   = (cand == key);
endmodule

FILE: rtl/bis_seq.sv
`include "block_indexed_search_top_macros.svh"

module bis_seq (
   input  logic                clock,
   input  logic                reset,
   input  bis_pkg::cfg_type    cfg,
   bis_req_if.sink             req,
   bis_rsp_if.source           rsp,
   input  bis_pkg::elem_type   rdata,
   input  bis_pkg::elem_type   max_sel,
   output bis_pkg::load_type   ld,
   output bis_pkg::rd_type     rd,
   output bis_pkg::biu_type    sel_blk
);
   import bis_pkg::*;

   state_type state_ff, state_in;

   elem_type key_ff, key_in;
   biu_type  blk_ff, blk_in;
   biu_type  best_ff, best_in;
   elem_type bestmax_ff, bestmax_in;
   logic     have_ff, have_in;
   len_type  o_ff, o_in;
   logic     pend_ff, pend_in;
   len_type  pend_o_ff, pend_o_in;
   logic     res_found_ff, res_found_in;
   biu_type  res_blk_ff, res_blk_in;
   len_type  res_off_ff, res_off_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_found_ff, out_found_in;
   blk_fld_type out_blk_ff, out_blk_in;
   off_fld_type out_off_ff, out_off_in;
   pos_type     out_pos_ff, out_pos_in;

   elem_type cand;
   cmp_type  cmp;
   logic     accept;
   logic     out_free;
   logic     sel_more;
   logic     scan_hit;
   logic     scan_miss;
   logic [7:0] pos_wide;

   bis_cmp u_cmp (
      .cand  (cand),
      .key   (key_ff),
      .bound (bestmax_ff),
      .res   (cmp)
   );

   assign cand      = (state_ff == ST_SCAN) ? rdata : max_sel;
   assign accept    = req.valid && req.ready;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign sel_more  = (blk_ff < cfg.blocks_in_use);
   assign scan_hit  = pend_ff && cmp.eq_key;
   assign scan_miss = !pend_ff && (o_ff >= cfg.block_length);
   assign pos_wide  = 8'(res_blk_ff) * 8'(cfg.block_length) + 8'(res_off_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.command == CMD_SEARCH)) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (!sel_more) begin
               state_in = have_ff ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready    = (state_ff == ST_IDLE);
      ld.en        = accept && (req.command == CMD_LOAD);
      ld.blk       = req.block_number;
      ld.off       = req.offset;
      ld.value     = req.element_value;
      rd.en        = 1'b0;
      rd.blk       = best_ff;
      rd.off       = o_ff;
      sel_blk      = blk_ff;

      key_in       = key_ff;
      blk_in       = blk_ff;
      best_in      = best_ff;
      bestmax_in   = bestmax_ff;
      have_in      = have_ff;
      o_in         = o_ff;
      pend_in      = 1'b0;
      pend_o_in    = o_ff;
      res_found_in = res_found_ff;
      res_blk_in   = res_blk_ff;
      res_off_in   = res_off_ff;

      out_valid_in = out_valid_ff && !rsp.ready;
      out_found_in = out_found_ff;
      out_blk_in   = out_blk_ff;
      out_off_in   = out_off_ff;
      out_pos_in   = out_pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.command == CMD_SEARCH)) begin
               key_in       = req.search_key;
               blk_in       = '0;
               have_in      = 1'b0;
               res_found_in = 1'b0;
               res_blk_in   = '0;
               res_off_in   = '0;
            end
         end
         ST_SELECT: begin
            if (sel_more) begin
               if (cmp.ge_key && (!have_ff || cmp.lt_bound)) begin
                  best_in    = blk_ff;
                  bestmax_in = max_sel;
                  have_in    = 1'b1;
               end
               blk_in = blk_ff + biu_type'(1);
            end else begin
               o_in = '0;
            end
         end
         ST_SCAN: begin
            rd.en     = (o_ff < cfg.block_length);
            pend_in   = rd.en;
            pend_o_in = o_ff;
            if (rd.en) begin
               o_in = o_ff + len_type'(1);
            end
            if (scan_hit) begin
               res_found_in = 1'b1;
               res_blk_in   = best_ff;
               res_off_in   = pend_o_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_found_in = res_found_ff;
               out_blk_in   = res_blk_ff[1:0];
               out_off_in   = res_off_ff[2:0];
               out_pos_in   = pos_wide[4:0];
            end
         end
         default: begin
            out_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         have_ff      <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      blk_ff       <= blk_in;
      best_ff      <= best_in;
      bestmax_ff   <= bestmax_in;
      o_ff         <= o_in;
      pend_o_ff    <= pend_o_in;
      res_found_ff <= res_found_in;
      res_blk_ff   <= res_blk_in;
      res_off_ff   <= res_off_in;
      out_found_ff <= out_found_in;
      out_blk_ff   <= out_blk_in;
      out_off_ff   <= out_off_in;
      out_pos_ff   <= out_pos_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.found          = out_found_ff;
   assign rsp.found_block    = out_blk_ff;
   assign rsp.found_offset   = out_off_ff;
   assign rsp.found_position = out_pos_ff;

   `BIS_ASSERT_NEXT(a_search_start, clock, reset, accept && (req.command == CMD_SEARCH), (state_ff == ST_SELECT) && (blk_ff == '0) && !have_ff)
   `BIS_ASSERT_IMP(a_miss_zero, clock, reset, rsp.valid && !rsp.found, (rsp.found_block == '0) && (rsp.found_offset == '0) && (rsp.found_position == '0))
   `BIS_ASSERT_IMP(a_hit_in_range, clock, reset, rsp.valid && rsp.found, (3'(rsp.found_block) < cfg.blocks_in_use) && (4'(rsp.found_offset) < cfg.block_length))
   `BIS_ASSERT_IMP(a_scan_bound, clock, reset, (state_ff == ST_SCAN) && pend_ff, pend_o_ff < cfg.block_length)
endmodule

FILE: rtl/block_indexed_search_top.sv
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   command, block_number, offset, element_value, search_key
// rsp       out  valid/ready   found, found_block, found_offset, found_position
// csr       in   APB write     blocks_in_use (0x0), block_length (0x4)
//
// A load is written into the store from the idle state; req stays ready behind it.
// A search runs the select state, one maximum per cycle through the shared comparator,
// then the scan state (skipped when no block maximum reaches the key), one element per cycle
// out of the registered store read port through the same comparator, then the done state.
// Reset is synchronous; it clears the block maxima and the sequencer.
// A stalled rsp holds its result; req closes while a search runs and until its result is registered.
module block_indexed_search_top #(
   parameter int MAX_BLOCKS    = bis_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_BLOCK_LEN = bis_pkg::DEF_MAX_BLOCK_LEN
) (
   input  logic                            clock,
   input  logic                            reset,
   bis_req_if.sink                         req,
   bis_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bis_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bis_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bis_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import bis_pkg::*;

   cfg_type  cfg;
   load_type ld;
   rd_type   rd;
   biu_type  sel_blk;
   elem_type rdata;
   elem_type max_sel;

   bis_csr #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bis_store #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .ld      (ld),
      .rd      (rd),
      .sel_blk (sel_blk),
      .rdata   (rdata),
      .max_sel (max_sel)
   );

   bis_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req),
      .rsp     (rsp),
      .rdata   (rdata),
      .max_sel (max_sel),
      .ld      (ld),
      .rd      (rd),
      .sel_blk (sel_blk)
   );
endmodule

FILE: sim/block_indexed_search_top_test.sv
module block_indexed_search_top_test;
   import bis_pkg::*;

   localparam int RUN_LIMIT     = 4000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 600;
   localparam int PHASE_ITEMS   = 190;
   localparam int NUM_BLOCKS    = DEF_MAX_BLOCKS;
   localparam int NUM_LEN       = DEF_MAX_BLOCK_LEN;
   localparam int NUM_SLOTS     = NUM_BLOCKS * NUM_LEN;
   localparam int ELEM_MIN      = -32768;
   localparam int ELEM_MAX      = 32767;
   localparam int NUM_PLAN      = 7;
   localparam int NUM_PRELOAD   = 18;
   localparam int NUM_PROBES    = 9;

   // blocks 0 and 1 tie on a maximum of 20; block 2 peaks at 1000
   localparam int PRELOAD [NUM_PRELOAD] = '{
      ELEM_MIN, 5, 10, 5, -1, 20,
      7, 20, 3, 20, 0, 1,
      1000, 100, -5, 100, 2, 3
   };
   localparam int PROBES [NUM_PROBES] = '{20, 5, 7, ELEM_MAX, ELEM_MIN, 1000, 100, 0, 30000};
   localparam int BIU_PLAN [NUM_PLAN] = '{7, 0, 4, 1, 2, 5, 3};
   localparam int LEN_PLAN [NUM_PLAN] = '{15, 0, 1, 8, 3, 7, 4};

   typedef struct packed {
      logic        command;
      blk_fld_type blk;
      off_fld_type off;
      elem_type    value;
      elem_type    key;
   } entry_op_type;

   typedef struct packed {
      logic        found;
      blk_fld_type blk;
      off_fld_type off;
      pos_type     pos;
   } hit_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_PERIODIC,
      RX_SPARSE
   } rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bis_req_if req_ch ();
   bis_rsp_if rsp_ch ();

   block_indexed_search_top uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   entry_op_type op_backlog [$];
   hit_type      hits_due [$];

   int shadow_elem [NUM_SLOTS];
   int shadow_max [NUM_BLOCKS];
   int gen_vals [NUM_SLOTS];
   int cur_biu;
   int cur_len;

   int          err_count;
   bit          req_fired;
   bit          sender_hold;
   int          stall_asks;
   int          tx_gap_left;
   int          tx_burst_left = 1;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_mode_left;
   int          rx_tick;
   int          rx_period = 2;
   int          rx_busy = 1;
   int          rx_hold_left;
   int          rx_stalls_taken;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("block_indexed_search_top_test: errors");
      $finish;
   end

   task automatic flag_mismatch(string what, int got, int want);
      err_count++;
      $display("%0t mismatch on %0s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic hit_type locate_key(int key);
      hit_type hit;
      int      best;
      bit      have;
      hit = '0;
      best = 0;
      have = 1'b0;
      for (int b = 0; b < cur_biu; b++) begin
         if (shadow_max[b] >= key && (!have || shadow_max[b] < shadow_max[best])) begin
            best = b;
            have = 1'b1;
         end
      end
      if (have) begin
         for (int o = 0; o < cur_len && !hit.found; o++) begin
            if (shadow_elem[best * NUM_LEN + o] == key) begin
               hit.found = 1'b1;
               hit.blk = 2'(best);
               hit.off = 3'(o);
               hit.pos = 5'(best * cur_len + o);
            end
         end
      end
      return hit;
   endfunction

   function automatic int pick_value();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 55) return int'($urandom_range(0, 40)) - 20;
      if (roll < 80) return int'($urandom_range(0, 2000)) - 1000;
      if (roll < 86) return ($urandom_range(0, 1) != 0) ? ELEM_MAX : ELEM_MIN;
      return int'($signed(16'($urandom())));
   endfunction

   function automatic entry_op_type make_load(int blk, int off, int value);
      entry_op_type op;
      op.command = CMD_LOAD;
      op.blk = 2'(blk);
      op.off = 3'(off);
      op.value = 16'(value);
      op.key = 16'($urandom());
      gen_vals[blk * NUM_LEN + off] = value;
      return op;
   endfunction

   function automatic entry_op_type make_search(int key);
      entry_op_type op;
      op.command = CMD_SEARCH;
      op.blk = 2'($urandom());
      op.off = 3'($urandom());
      op.value = 16'($urandom());
      op.key = 16'(key);
      return op;
   endfunction

   function automatic entry_op_type random_op();
      int roll;
      int key;
      if ($urandom_range(0, 1) == 0) begin
         return make_load(int'($urandom_range(0, 3)), int'($urandom_range(0, 7)), pick_value());
      end
      roll = int'($urandom_range(0, 99));
      if (roll < 45) begin
         key = gen_vals[$urandom_range(0, NUM_SLOTS - 1)];
      end else if (roll < 55) begin
         key = gen_vals[$urandom_range(0, NUM_SLOTS - 1)] + 1;
      end else if (roll < 70) begin
         key = int'($urandom_range(0, 40)) - 20;
      end else if (roll < 78) begin
         key = ($urandom_range(0, 1) != 0) ? ELEM_MAX : ELEM_MIN;
      end else begin
         key = int'($signed(16'($urandom())));
      end
      return make_search(key);
   endfunction

   task automatic settle();
      while (op_backlog.size() != 0 || req_ch.valid || hits_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic sel, int raw);
      logic [CSR_DATA_W-1:0] data;
      int                    field;
      data = ($urandom_range(0, 1) != 0) ? $urandom() : '0;
      if (sel == REG_BLOCK_LENGTH) begin
         data[3:0] = 4'(raw);
      end else begin
         data[2:0] = 3'(raw);
      end
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {sel, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (sel == REG_BLOCK_LENGTH) begin
         field = int'(data[3:0]);
         cur_len = (field < 1) ? 1 : (field > NUM_LEN) ? NUM_LEN : field;
      end else begin
         field = int'(data[2:0]);
         cur_biu = (field < 1) ? 1 : (field > NUM_BLOCKS) ? NUM_BLOCKS : field;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(int biu_raw, int len_raw);
      settle();
      csr_write(REG_BLOCKS_IN_USE, biu_raw);
      csr_write(REG_BLOCK_LENGTH, len_raw);
   endtask

   always @(negedge clock) begin : drive
      entry_op_type op;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (tx_gap_left > 0) begin
            tx_gap_left--;
            req_ch.valid <= 1'b0;
         end else if (op_backlog.size() != 0 && !sender_hold) begin
            op = op_backlog.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.command <= op.command;
            req_ch.block_number <= op.blk;
            req_ch.offset <= op.off;
            req_ch.element_value <= op.value;
            req_ch.search_key <= op.key;
            tx_burst_left--;
            if (tx_burst_left <= 0) begin
               tx_burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(100, 250))
                                                          : int'($urandom_range(1, 20));
               tx_gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : accept
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rx_stalls_taken != stall_asks) begin
            rx_stalls_taken = stall_asks;
            rx_hold_left = LONG_HOLD;
         end
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = int'($urandom_range(40, 300));
            rx_period = int'($urandom_range(2, 9));
            rx_busy = int'($urandom_range(1, rx_period - 1));
         end else begin
            rx_mode_left--;
         end
         rx_tick++;
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:     rsp_ch.ready <= 1'b1;
               RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_ch.ready <= (rx_tick % rx_period) >= rx_busy;
               default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : observe
      int      slot;
      int      val;
      hit_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.command == CMD_SEARCH) begin
               hits_due.push_back(locate_key(int'(req_ch.search_key)));
            end else if (int'(req_ch.offset) < cur_len) begin
               slot = int'(req_ch.block_number) * NUM_LEN + int'(req_ch.offset);
               val = int'(req_ch.element_value);
               shadow_elem[slot] = val;
               if (val > shadow_max[req_ch.block_number]) begin
                  shadow_max[req_ch.block_number] = val;
               end
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (hits_due.size() == 0) begin
               flag_mismatch("result with no search outstanding",
                             int'(rsp_ch.found_position), -1);
            end else begin
               want = hits_due.pop_front();
               if (rsp_ch.found !== want.found) begin
                  flag_mismatch("found", int'(rsp_ch.found), int'(want.found));
               end
               if (rsp_ch.found_block !== want.blk) begin
                  flag_mismatch("found_block", int'(rsp_ch.found_block), int'(want.blk));
               end
               if (rsp_ch.found_offset !== want.off) begin
                  flag_mismatch("found_offset", int'(rsp_ch.found_offset), int'(want.off));
               end
               if (rsp_ch.found_position !== want.pos) begin
                  flag_mismatch("found_position", int'(rsp_ch.found_position),
                                int'(want.pos));
               end
            end
         end
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_LOAD;
      req_ch.block_number = '0;
      req_ch.offset = '0;
      req_ch.element_value = '0;
      req_ch.search_key = '0;
      rsp_ch.ready = 1'b0;
      cur_biu = BIU_RESET;
      cur_len = BLEN_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_elem[i] = 0;
         gen_vals[i] = 0;
      end
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         shadow_max[b] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: three blocks of six
      for (int i = 0; i < NUM_PRELOAD; i++) begin
         op_backlog.push_back(make_load(i / 6, i % 6, PRELOAD[i]));
      end
      // drop: offsets past the block length (block 3 is still written, outside blocks_in_use)
      op_backlog.push_back(make_load(0, 6, 30000));
      op_backlog.push_back(make_load(0, 7, 30000));
      op_backlog.push_back(make_load(3, 0, ELEM_MAX));
      for (int i = 0; i < NUM_PROBES; i++) begin
         op_backlog.push_back(make_search(PROBES[i]));
      end

      for (int p = 0; p < NUM_PLAN; p++) begin
         configure(BIU_PLAN[p], LEN_PLAN[p]);
         if (p == 0) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               op_backlog.push_back(make_load(s / NUM_LEN, s % NUM_LEN, pick_value()));
            end
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            op_backlog.push_back(random_op());
         end
         if (p == 2) begin
            stall_asks++;
         end
         if (p == 4) begin
            while (op_backlog.size() > PHASE_ITEMS / 2) @(posedge clock);
            sender_hold = 1'b1;
            while (hits_due.size() != 0 || req_ch.valid) @(posedge clock);
            sender_hold = 1'b0;
         end
      end

      configure(int'($urandom_range(0, 7)), int'($urandom_range(0, 15)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         op_backlog.push_back(random_op());
      end
      settle();

      if (err_count == 0) begin
         $display("block_indexed_search_top_test: clean");
      end else begin
         $display("block_indexed_search_top_test: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bis_pkg.sv
rtl/bis_if.sv
rtl/bis_csr.sv
rtl/bis_store.sv
rtl/bis_cmp.sv
rtl/bis_seq.sv
rtl/block_indexed_search_top.sv
sim/block_indexed_search_top_test.sv
